// ----- src/button_debounce_press_classifier_top_macros.svh -----
// assertion macros used by the checker file bdpc_checker.sv
`ifndef BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH
`define BUTTON_DEBOUNCE_PRESS_CLASSIFIER_TOP_MACROS_SVH

// property checked on every clock edge outside reset
`define BDPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every clock edge, reset included
`define BDPC_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- src/bdpc_pkg.sv -----
// types and constants of the button debounce and press classifier
`default_nettype none

package bdpc_pkg;

    localparam int TIME_W  = 32;
    localparam int CFG_W   = 16;
    localparam int COUNT_W = 8;
    localparam int CFG_IDX_W = 3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD3     = 3'd4;

    // reset values of the configuration registers
    localparam logic [CFG_W-1:0] RST_DEBOUNCE  = 16'd15;
    localparam logic [CFG_W-1:0] RST_SHORT_MAX = 16'd1000;
    localparam logic [CFG_W-1:0] RST_HOLD1     = 16'd1000;
    localparam logic [CFG_W-1:0] RST_HOLD2     = 16'd2000;
    localparam logic [CFG_W-1:0] RST_HOLD3     = 16'd3000;

    localparam logic LEVEL_RELEASED = 1'b1;

    typedef struct packed {
        logic              pin_level;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic               stable_level_out;
        logic               press_event;
        logic               release_event;
        logic               short_press_event;
        logic               hold1_event;
        logic               hold2_event;
        logic               hold3_event;
        logic [COUNT_W-1:0] short_press_total;
    } t_out_item;

endpackage

`default_nettype wire

// ----- src/button_debounce_press_classifier_top.sv -----
// top level of the button debounce and press classifier
`default_nettype none

// Takes one poll (raw active-low pin level plus millisecond tick) per clock and returns one
// result per poll: the debounced level, press/release/short-press events, hold window flags
// and the running short-press count. Each request passes an input register, then one pass
// of logic (two 32-bit wrapping subtracts and their compares against the configured limits)
// into the result register; a new poll can be taken every cycle while the result side keeps up.
// Configuration writes are taken at once and belong in idle periods; a stalled result side
// stalls the input.
module button_debounce_press_classifier_top (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    output logic                            o_in_ready,
    input  bdpc_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  wire                             i_out_ready,
    output bdpc_pkg::t_out_item             o_out_data,
    input  wire                             i_cfg_valid,
    output logic                            o_cfg_ready,
    input  wire [bdpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bdpc_pkg::CFG_W-1:0]       i_cfg_data
);
    import bdpc_pkg::*;

    // configuration
    logic [CFG_W-1:0] r_debounce;
    logic [CFG_W-1:0] r_short_max;
    logic [CFG_W-1:0] r_hold1;
    logic [CFG_W-1:0] r_hold2;
    logic [CFG_W-1:0] r_hold3;

    // pipeline
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;

    // classifier state
    logic               r_raw_seen;
    logic               r_settling;
    logic [TIME_W-1:0]  r_change_time;
    logic               r_stable;
    logic               r_holding;
    logic [TIME_W-1:0]  r_press_time;
    logic [COUNT_W-1:0] r_short_cnt;

    logic               raw_diff;
    logic               settling_pre;
    logic [TIME_W-1:0]  n_change_time;
    logic [TIME_W-1:0]  settle_age;
    logic               settle_done;
    logic               n_settling;
    logic               n_stable;
    logic               press;
    logic               release_ev;
    logic [TIME_W-1:0]  n_press_time;
    logic [TIME_W-1:0]  held;
    logic               short_ev;
    logic [COUNT_W-1:0] n_short_cnt;
    logic               hold_pre;
    logic               hold1;
    logic               hold2;
    logic               hold3;
    logic               n_holding;

    assign advance     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        raw_diff      = r_in.pin_level != r_raw_seen;
        settling_pre  = raw_diff || r_settling;
        n_change_time = raw_diff ? r_in.now_ms : r_change_time;
        settle_age    = r_in.now_ms - n_change_time;
        settle_done   = settling_pre && (settle_age >= {{(TIME_W-CFG_W){1'b0}}, r_debounce});
        n_settling    = settling_pre && !settle_done;
        n_stable      = settle_done ? r_in.pin_level : r_stable;

        press         = (n_stable != r_stable) && !n_stable;
        release_ev    = (n_stable != r_stable) && n_stable;
        n_press_time  = press ? r_in.now_ms : r_press_time;
        held          = r_in.now_ms - n_press_time;

        short_ev      = release_ev && (held <= {{(TIME_W-CFG_W){1'b0}}, r_short_max});
        n_short_cnt   = r_short_cnt + {{(COUNT_W-1){1'b0}}, short_ev};

        // hold checks run after press/release handling, highest window first
        hold_pre      = press || (r_holding && !release_ev);
        hold3         = hold_pre && (held >= {{(TIME_W-CFG_W){1'b0}}, r_hold3});
        hold2         = hold_pre && !hold3 && (held >= {{(TIME_W-CFG_W){1'b0}}, r_hold2});
        hold1         = hold_pre && !hold3 && !hold2
                        && (held >= {{(TIME_W-CFG_W){1'b0}}, r_hold1});
        n_holding     = hold_pre && !hold3;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce  <= RST_DEBOUNCE;
            r_short_max <= RST_SHORT_MAX;
            r_hold1     <= RST_HOLD1;
            r_hold2     <= RST_HOLD2;
            r_hold3     <= RST_HOLD3;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DEBOUNCE:  r_debounce  <= i_cfg_data;
                CFG_SHORT_MAX: r_short_max <= i_cfg_data;
                CFG_HOLD1:     r_hold1     <= i_cfg_data;
                CFG_HOLD2:     r_hold2     <= i_cfg_data;
                CFG_HOLD3:     r_hold3     <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_raw_seen    <= LEVEL_RELEASED;
            r_settling    <= 1'b0;
            r_change_time <= '0;
            r_stable      <= LEVEL_RELEASED;
            r_holding     <= 1'b0;
            r_press_time  <= '0;
            r_short_cnt   <= '0;
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (advance) begin
                r_raw_seen    <= r_in.pin_level;
                r_settling    <= n_settling;
                r_change_time <= n_change_time;
                r_stable      <= n_stable;
                r_holding     <= n_holding;
                r_press_time  <= n_press_time;
                r_short_cnt   <= n_short_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (advance) begin
            r_out.stable_level_out  <= n_stable;
            r_out.press_event       <= press;
            r_out.release_event     <= release_ev;
            r_out.short_press_event <= short_ev;
            r_out.hold1_event       <= hold1;
            r_out.hold2_event       <= hold2;
            r_out.hold3_event       <= hold3;
            r_out.short_press_total <= n_short_cnt;
        end
    end

endmodule

`default_nettype wire

// ----- src/bdpc_checker.sv -----
// port-level checks for the button debounce and press classifier, bound to the top level
`default_nettype none

`include "button_debounce_press_classifier_top_macros.svh"

module bdpc_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             o_in_ready,
    input  bdpc_pkg::t_in_item              i_in_data,
    input  wire                             o_out_valid,
    input  wire                             i_out_ready,
    input  bdpc_pkg::t_out_item             o_out_data,
    input  wire                             i_cfg_valid,
    input  wire                             o_cfg_ready,
    input  wire [bdpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bdpc_pkg::CFG_W-1:0]       i_cfg_data
);
    import bdpc_pkg::*;

    // a stalled result holds
    `BDPC_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data), "stalled result changed")

    // no result right after reset
    `BDPC_ASSERT_ALWAYS(a_reset_empty, i_clk, $past(!i_rst_n) |-> !o_out_valid, "result valid after reset")

    `BDPC_ASSERT(a_hold_onehot, i_clk, i_rst_n, o_out_valid |-> $onehot0({o_out_data.hold1_event, o_out_data.hold2_event, o_out_data.hold3_event}), "more than one hold flag")

    // edge events agree with the level they lead to
    `BDPC_ASSERT(a_edge_level, i_clk, i_rst_n, o_out_valid |-> (!o_out_data.press_event || !o_out_data.stable_level_out) && (!o_out_data.release_event || o_out_data.stable_level_out), "edge event against level")

    // a short press is a release with no hold flag
    `BDPC_ASSERT(a_short_release, i_clk, i_rst_n, o_out_valid && o_out_data.short_press_event |-> o_out_data.release_event && !o_out_data.hold1_event && !o_out_data.hold2_event && !o_out_data.hold3_event, "short press without release")

endmodule

bind button_debounce_press_classifier_top bdpc_checker u_bdpc_checker (.*);

`default_nettype wire

// ----- bench/button_debounce_press_classifier_checker.sv -----
// predicts each poll's result and compares it with the block's output channel
`timescale 1ns / 1ps

module button_debounce_press_classifier_checker (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  wire                             i_in_valid,
    input  wire                             i_in_ready,
    input  bdpc_pkg::t_in_item              i_in_data,
    input  wire                             i_out_valid,
    input  wire                             i_out_ready,
    input  bdpc_pkg::t_out_item             i_out_data,
    input  wire                             i_cfg_valid,
    input  wire                             i_cfg_ready,
    input  wire [bdpc_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  wire [bdpc_pkg::CFG_W-1:0]       i_cfg_data,
    output int                              o_mismatches,
    output int                              o_results_owed
);
    import bdpc_pkg::*;

    localparam int PRINT_LIMIT = 20;

    logic [CFG_W-1:0]   debounce_lim, short_lim, hold1_lim, hold2_lim, hold3_lim;
    logic               raw_last, settling, debounced, debounced_prev, held_down;
    logic [TIME_W-1:0]  raw_change_ms, press_ms;
    logic [COUNT_W-1:0] short_count;

    t_out_item owed_results[$];
    int        mismatch_count = 0;

    assign o_mismatches = mismatch_count;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_count++;
    endtask

    // one poll through debounce, edge handling and the hold window chain
    task automatic classify_poll(input t_in_item poll, output t_out_item res);
        logic [TIME_W-1:0] since_change;
        logic [TIME_W-1:0] held_for;
        res = '0;
        if (poll.pin_level != raw_last) begin
            settling      = 1'b1;
            raw_last      = poll.pin_level;
            raw_change_ms = poll.now_ms;
        end
        since_change = poll.now_ms - raw_change_ms;
        if (settling && since_change >= {16'd0, debounce_lim}) begin
            settling  = 1'b0;
            debounced = poll.pin_level;
        end

        if (debounced != debounced_prev) begin
            if (debounced == 1'b0) begin
                held_down       = 1'b1;
                press_ms        = poll.now_ms;
                res.press_event = 1'b1;
            end else begin
                held_down = 1'b0;
                held_for  = poll.now_ms - press_ms;
                if (held_for <= {16'd0, short_lim}) begin
                    short_count           = short_count + 1'b1;
                    res.short_press_event = 1'b1;
                end
                res.release_event = 1'b1;
            end
            debounced_prev = debounced;
        end

        // hold3 wins over hold2 over hold1, whatever order the limits are in
        if (held_down) begin
            held_for = poll.now_ms - press_ms;
            if (held_for >= {16'd0, hold3_lim}) begin
                res.hold3_event = 1'b1;
                held_down       = 1'b0;
            end else if (held_for >= {16'd0, hold2_lim}) begin
                res.hold2_event = 1'b1;
            end else if (held_for >= {16'd0, hold1_lim}) begin
                res.hold1_event = 1'b1;
            end
        end

        res.stable_level_out  = debounced;
        res.short_press_total = short_count;
    endtask

    task automatic compare_result(input t_out_item got, input t_out_item want);
        if (got.stable_level_out !== want.stable_level_out)
            report_mismatch("stable_level_out", got.stable_level_out, want.stable_level_out);
        if (got.press_event !== want.press_event)
            report_mismatch("press_event", got.press_event, want.press_event);
        if (got.release_event !== want.release_event)
            report_mismatch("release_event", got.release_event, want.release_event);
        if (got.short_press_event !== want.short_press_event)
            report_mismatch("short_press_event", got.short_press_event,
                            want.short_press_event);
        if (got.hold1_event !== want.hold1_event)
            report_mismatch("hold1_event", got.hold1_event, want.hold1_event);
        if (got.hold2_event !== want.hold2_event)
            report_mismatch("hold2_event", got.hold2_event, want.hold2_event);
        if (got.hold3_event !== want.hold3_event)
            report_mismatch("hold3_event", got.hold3_event, want.hold3_event);
        if (got.short_press_total !== want.short_press_total)
            report_mismatch("short_press_total", got.short_press_total,
                            want.short_press_total);
    endtask

    always @(posedge i_clk) begin : sample
        t_out_item want;
        if (!i_rst_n) begin
            debounce_lim   = RST_DEBOUNCE;
            short_lim      = RST_SHORT_MAX;
            hold1_lim      = RST_HOLD1;
            hold2_lim      = RST_HOLD2;
            hold3_lim      = RST_HOLD3;
            raw_last       = LEVEL_RELEASED;
            settling       = 1'b0;
            raw_change_ms  = '0;
            debounced      = LEVEL_RELEASED;
            debounced_prev = LEVEL_RELEASED;
            held_down      = 1'b0;
            press_ms       = '0;
            short_count    = '0;
            owed_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_DEBOUNCE:  debounce_lim = i_cfg_data;
                    CFG_SHORT_MAX: short_lim    = i_cfg_data;
                    CFG_HOLD1:     hold1_lim    = i_cfg_data;
                    CFG_HOLD2:     hold2_lim    = i_cfg_data;
                    CFG_HOLD3:     hold3_lim    = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_out_valid && i_out_ready) begin
                if (owed_results.size() == 0) begin
                    report_mismatch("result with none owed", i_out_data, 0);
                end else begin
                    want = owed_results.pop_front();
                    compare_result(i_out_data, want);
                end
            end
            if (i_in_valid && i_in_ready) begin
                classify_poll(i_in_data, want);
                owed_results.push_back(want);
            end
        end
        o_results_owed <= owed_results.size();
    end

endmodule

// ----- bench/button_debounce_press_classifier_top_tb.sv -----
// testbench top: drives polls and register writes around the block and gives the verdict
`timescale 1ns / 1ps

module button_debounce_press_classifier_top_tb;
    import bdpc_pkg::*;

    localparam int IDLE_LIMIT      = 2000;
    localparam int DRAIN_CYCLES    = 8;
    localparam int PRESSURE_CYCLES = 80;
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_item             in_data;
    logic                 out_valid;
    logic                 out_ready;
    t_out_item            out_data;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    int mismatches;
    int results_owed;
    int idle_cycles = 0;

    logic [TIME_W-1:0] clock_ms;
    logic              last_pin;
    int                burst_left;
    int                polls_sent;
    bit                start_pressure;

    button_debounce_press_classifier_top dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    button_debounce_press_classifier_checker poll_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_in_data      (in_data),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_data     (out_data),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_mismatches   (mismatches),
        .o_results_owed (results_owed)
    );

    always begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("button_debounce_press_classifier_top: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // sender works in bursts; entered and left at a falling edge
    task automatic send_poll(input logic pin);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid          <= 1'b1;
        in_data.pin_level <= pin;
        in_data.now_ms    <= clock_ms;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        last_pin = pin;
        polls_sent++;
    endtask

    task automatic poll_after(input logic pin, input logic [TIME_W-1:0] delta);
        clock_ms = clock_ms + delta;
        send_poll(pin);
    endtask

    task automatic wait_cfg_taken;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
    endtask

    // only with no poll in flight
    task automatic configure(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] sht,
                             input logic [CFG_W-1:0] h1, input logic [CFG_W-1:0] h2,
                             input logic [CFG_W-1:0] h3, input bit poke_unmapped);
        in_valid <= 1'b0;
        burst_left = 0;
        while (results_owed != 0) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        cfg_data  <= deb;
        wait_cfg_taken();
        cfg_index <= CFG_SHORT_MAX;
        cfg_data  <= sht;
        wait_cfg_taken();
        cfg_index <= CFG_HOLD1;
        cfg_data  <= h1;
        wait_cfg_taken();
        cfg_index <= CFG_HOLD2;
        cfg_data  <= h2;
        wait_cfg_taken();
        cfg_index <= CFG_HOLD3;
        cfg_data  <= h3;
        wait_cfg_taken();
        if (poke_unmapped) begin
            cfg_index <= CFG_UNMAPPED;
            cfg_data  <= $urandom_range(0, 65535);
            wait_cfg_taken();
        end
        cfg_valid <= 1'b0;
    endtask

    // mostly bounce / hold / bounce / rest gestures, some raw noise and time jumps
    task automatic run_gestures(input int polls, input int step_max);
        int target;
        int k;
        target = polls_sent + polls;
        while (polls_sent < target) begin
            if ($urandom_range(0, 9) < 7) begin
                k = $urandom_range(0, 4);
                repeat (k) poll_after($urandom_range(0, 1), $urandom_range(0, step_max / 4));
                k = $urandom_range(1, 12);
                repeat (k) poll_after(1'b0, $urandom_range(1, step_max));
                k = $urandom_range(0, 4);
                repeat (k) poll_after($urandom_range(0, 1), $urandom_range(0, step_max / 4));
                k = $urandom_range(1, 4);
                repeat (k) poll_after(1'b1, $urandom_range(1, step_max));
            end else begin
                k = $urandom_range(1, 5);
                repeat (k)
                    poll_after($urandom_range(0, 1), ($urandom_range(0, 15) == 0) ?
                               $urandom() : $urandom_range(0, 4 * step_max));
            end
        end
    endtask

    // strict alternation, meant for zero debounce: every release is short
    task automatic run_taps(input int polls);
        repeat (polls) poll_after(~last_pin, $urandom_range(0, 6));
    endtask

    initial begin : result_side
        int mode;
        int span;
        int beat;
        bit held_off;
        out_ready = 1'b0;
        held_off  = 1'b0;
        beat      = 0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 64);
            repeat (span) begin
                @(negedge clk);
                beat++;
                if (start_pressure && !held_off) begin
                    // long stall while requests keep coming, so the input side backs up
                    held_off = 1'b1;
                    out_ready <= 1'b0;
                    repeat (PRESSURE_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       out_ready <= 1'b1;
                    1:       out_ready <= ($urandom_range(0, 3) != 0);
                    2:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= (beat % 3 != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        int h1;
        int h2;
        int h3;
        int deb;
        int step;
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        in_data        = '0;
        cfg_valid      = 1'b0;
        cfg_index      = CFG_DEBOUNCE;
        cfg_data       = '0;
        burst_left     = 0;
        polls_sent     = 0;
        start_pressure = 1'b0;
        last_pin       = LEVEL_RELEASED;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset limits; bounce, then debounce met right across the time wrap
        clock_ms = 32'hFFFF_FFF0;
        poll_after(1'b1, 0);
        poll_after(1'b0, 1);
        poll_after(1'b1, 2);
        poll_after(1'b0, 2);
        poll_after(1'b0, 10);
        poll_after(1'b0, 5);
        poll_after(1'b0, 999);
        poll_after(1'b0, 1);
        poll_after(1'b0, 1000);
        poll_after(1'b0, 1000);
        poll_after(1'b0, 500);
        poll_after(1'b1, 1);
        poll_after(1'b1, 15);
        // hold of exactly the short limit
        poll_after(1'b0, 5);
        poll_after(1'b0, 15);
        poll_after(1'b1, 985);
        poll_after(1'b1, 15);

        // zero limits: press and hold3 on one poll, zero-length short press
        configure(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b1);
        poll_after(1'b0, 3);
        poll_after(1'b1, 0);

        // all limits at the top of their range
        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        poll_after(1'b0, 1);
        poll_after(1'b0, 65534);
        poll_after(1'b0, 1);
        poll_after(1'b0, 65535);
        poll_after(1'b1, 1);
        poll_after(1'b1, 65535);

        configure(RST_DEBOUNCE, RST_SHORT_MAX, RST_HOLD1, RST_HOLD2, RST_HOLD3, 1'b0);
        start_pressure = 1'b1;
        clock_ms = $urandom();
        run_gestures(80, 600);

        // enough taps to wrap the short-press count
        configure(16'd0, 16'hFFFF, $urandom_range(0, 6), $urandom_range(0, 12),
                  $urandom_range(0, 20), 1'b0);
        run_taps(520);

        configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
        run_gestures(40, 40000);

        // hold limits in reverse order
        h3 = $urandom_range(0, 60);
        h2 = h3 + $urandom_range(1, 60);
        h1 = h2 + $urandom_range(1, 60);
        configure($urandom_range(0, 10), $urandom_range(0, 200), h1, h2, h3, 1'b0);
        run_gestures(60, 30);

        deb = $urandom_range(0, 65535);
        h3  = $urandom_range(0, 65535);
        step = ((deb > h3) ? deb : h3) / 6 + 1;
        configure(deb, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), h3, 1'b0);
        run_gestures(40, step);

        configure(16'd1, 16'd5, 16'd3, 16'd6, 16'd9, 1'b1);
        run_gestures(40, 4);

        in_valid <= 1'b0;
        while (results_owed != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("button_debounce_press_classifier_top: match");
        else
            $display("button_debounce_press_classifier_top: mismatch");
        $finish;
    end

endmodule
